/* sv/remote_command_byte_decoder_macros.svh */
// Assertion macros for the remote command byte decoder.
`ifndef REMOTE_COMMAND_BYTE_DECODER_MACROS_SVH
`define REMOTE_COMMAND_BYTE_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RCBD_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RCBD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rcbd_pkg.sv */
// Package: byte codes, motion and gear codes for the remote command byte decoder.
`default_nettype none

package rcbd_pkg;

    localparam logic [7:0] CH_LOW_GEAR  = 8'h59;
    localparam logic [7:0] CH_HIGH_GEAR = 8'h58;
    localparam logic [7:0] CH_STOP      = 8'h5A;
    localparam logic [7:0] CH_FORWARD   = 8'h41;
    localparam logic [7:0] CH_BACK      = 8'h45;
    localparam logic [7:0] CH_RIGHT_0   = 8'h42;
    localparam logic [7:0] CH_RIGHT_1   = 8'h43;
    localparam logic [7:0] CH_RIGHT_2   = 8'h44;
    localparam logic [7:0] CH_LEFT_0    = 8'h46;
    localparam logic [7:0] CH_LEFT_1    = 8'h47;
    localparam logic [7:0] CH_LEFT_2    = 8'h48;
    localparam logic [7:0] CH_OPEN      = 8'h7B;
    localparam logic [7:0] CH_CLOSE     = 8'h7D;
    localparam logic [7:0] CH_REPORT    = 8'h50;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LAST_SEL  = 8'h35;

    typedef enum logic [2:0] {
        MOTION_STOP    = 3'd0,
        MOTION_FORWARD = 3'd1,
        MOTION_BACK    = 3'd2,
        MOTION_LEFT    = 3'd3,
        MOTION_RIGHT   = 3'd4
    } motion_t;

    typedef enum logic [1:0] {
        GEAR_HIGH = 2'd1,
        GEAR_LOW  = 2'd2
    } gear_t;

endpackage

`default_nettype wire

/* sv/rcbd_ifs.sv */
// Channel interfaces: received byte in, decoded command out.
`default_nettype none

interface rcbd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rcbd_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         motion;
    logic [1:0]         speed_gear;
    logic               param_write;
    logic [2:0]         param_select;
    logic signed [31:0] param_value;
    logic               report_request;

    modport source (output valid, output motion, output speed_gear, output param_write,
                    output param_select, output param_value, output report_request,
                    input ready);
    modport sink   (input valid, input motion, input speed_gear, input param_write,
                    input param_select, input param_value, input report_request,
                    output ready);
endinterface

`default_nettype wire

/* sv/remote_command_byte_decoder.sv */
// Remote command byte decoder: one received byte in, one decoded command item out.
//
// rx carries one received byte per item (valid/ready). res carries one result
// item per accepted byte: motion, current speed gear, a gain write (select and
// saturated decimal value) when a '}' closes a parameter frame, and a report
// request when the frame's fourth byte is 'P'.
// The result of an accepted byte is registered and shows on res in the cycle
// after acceptance. Throughput is one item per cycle while res is not stalled; the
// decode, the times-ten accumulate and the saturation sit between the input
// handshake and the result register.
// rx.ready is high while the result register is empty or being taken, so a
// stalled receiver holds the result in place and stops input after one item.
// Frame bytes beyond FRAME_DEPTH are dropped while the frame stays open.
// Reset (rst_n low, asynchronous) empties the result register, selects the
// low speed gear and clears the open frame.
`default_nettype none
`include "remote_command_byte_decoder_macros.svh"

module remote_command_byte_decoder
    import rcbd_pkg::*;
#(
    parameter int FRAME_DEPTH = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rcbd_rx_if.sink   rx,
    rcbd_res_if.source res
);

    localparam int CNT_W = $clog2(FRAME_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FRAME_DEPTH);
    localparam logic signed [36:0] SAT_MAX = 37'sd2147483647;
    localparam logic signed [36:0] SAT_MIN = -37'sd2147483648;

    // frame state
    gear_t              gear_reg, gear_next;
    logic               collecting_reg, collecting_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [7:0]         sel_byte_reg, sel_byte_next;
    logic [7:0]         fourth_reg, fourth_next;
    logic signed [31:0] acc_reg, acc_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    motion_t            motion_reg, motion_next;
    gear_t              out_gear_reg;
    logic               wr_reg, wr_next;
    logic [2:0]         psel_reg, psel_next;
    logic signed [31:0] pval_reg, pval_next;
    logic               rep_reg, rep_next;

    logic               take;
    logic [7:0]         b;
    logic [7:0]         sel_off;
    logic signed [36:0] acc_wide;
    logic signed [36:0] acc_sum;

    assign take     = rx.valid && rx.ready;
    assign rx.ready = !out_valid_reg || res.ready;
    assign b        = rx.rx_byte;
    assign sel_off  = sel_byte_reg - CH_ZERO;

    // accumulator * 10 + (byte - '0')
    assign acc_wide = 37'(acc_reg);
    assign acc_sum  = (acc_wide <<< 3) + (acc_wide <<< 1) + 37'($signed({1'b0, b}))
                      - 37'sd48;

    always_comb
    begin
        gear_next       = gear_reg;
        collecting_next = collecting_reg;
        count_next      = count_reg;
        sel_byte_next   = sel_byte_reg;
        fourth_next     = fourth_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg;
        motion_next     = motion_reg;
        wr_next         = wr_reg;
        psel_next       = psel_reg;
        pval_next       = pval_reg;
        rep_next        = rep_reg;

        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (take)
        begin
            out_valid_next = 1'b1;

            if (b == CH_LOW_GEAR)
            begin
                gear_next = GEAR_LOW;
            end
            else if (b == CH_HIGH_GEAR)
            begin
                gear_next = GEAR_HIGH;
            end

            case (b)
                CH_FORWARD: motion_next = MOTION_FORWARD;
                CH_BACK:    motion_next = MOTION_BACK;
                CH_LEFT_0, CH_LEFT_1, CH_LEFT_2:    motion_next = MOTION_LEFT;
                CH_RIGHT_0, CH_RIGHT_1, CH_RIGHT_2: motion_next = MOTION_RIGHT;
                default:    motion_next = MOTION_STOP;
            endcase

            wr_next   = 1'b0;
            psel_next = 3'd0;
            pval_next = 32'sd0;
            rep_next  = 1'b0;

            if (b == CH_CLOSE)
            begin
                if (fourth_reg == CH_REPORT)
                begin
                    rep_next = 1'b1;
                end
                else if (sel_byte_reg >= CH_ZERO && sel_byte_reg <= CH_LAST_SEL)
                begin
                    wr_next   = 1'b1;
                    psel_next = sel_off[2:0];
                    pval_next = acc_reg;
                end
                collecting_next = 1'b0;
                count_next      = '0;
                sel_byte_next   = 8'd0;
                fourth_next     = 8'd0;
                acc_next        = 32'sd0;
            end
            else if ((collecting_reg || b == CH_OPEN) && count_reg < CNT_MAX)
            begin
                collecting_next = 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    sel_byte_next = b;
                end
                if (count_reg == CNT_W'(3))
                begin
                    fourth_next = b;
                end
                if (count_reg >= CNT_W'(3))
                begin
                    if (acc_sum > SAT_MAX)
                    begin
                        acc_next = 32'sh7FFF_FFFF;
                    end
                    else if (acc_sum < SAT_MIN)
                    begin
                        acc_next = 32'sh8000_0000;
                    end
                    else
                    begin
                        acc_next = acc_sum[31:0];
                    end
                end
                count_next = count_reg + CNT_W'(1);
            end
            else if (b == CH_OPEN)
            begin
                collecting_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gear_reg       <= GEAR_LOW;
            collecting_reg <= 1'b0;
            count_reg      <= '0;
            sel_byte_reg   <= 8'd0;
            fourth_reg     <= 8'd0;
            acc_reg        <= 32'sd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            gear_reg       <= gear_next;
            collecting_reg <= collecting_next;
            count_reg      <= count_next;
            sel_byte_reg   <= sel_byte_next;
            fourth_reg     <= fourth_next;
            acc_reg        <= acc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        motion_reg   <= motion_next;
        out_gear_reg <= (take) ? gear_next : out_gear_reg;
        wr_reg       <= wr_next;
        psel_reg     <= psel_next;
        pval_reg     <= pval_next;
        rep_reg      <= rep_next;
    end

    assign res.valid          = out_valid_reg;
    assign res.motion         = motion_reg;
    assign res.speed_gear     = out_gear_reg;
    assign res.param_write    = wr_reg;
    assign res.param_select   = psel_reg;
    assign res.param_value    = pval_reg;
    assign res.report_request = rep_reg;

    `RCBD_ASSERT_NEXT(a_close_ends_frame, take && b == CH_CLOSE, !collecting_reg && count_reg == '0, "close byte left frame open")
    `RCBD_ASSERT_NOW(a_count_bounded, 1'b1, count_reg <= CNT_MAX, "frame count past depth")
    `RCBD_ASSERT_NEXT(a_take_gives_result, take, res.valid, "accepted byte produced no result")
    `RCBD_ASSERT_NOW(a_write_or_report, res.valid && res.param_write, !res.report_request && res.param_select <= 3'd5, "bad gain write result")

endmodule

`default_nettype wire

/* test/tb.sv */
// Testbench for the remote command byte decoder: byte streams checked against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcbd_pkg::*;

    localparam int FRAME_DEPTH = 64;
    localparam logic [7:0] CH_HASH = 8'h23;

    typedef struct {
        motion_t            motion;
        gear_t              gear;
        logic               wr;
        logic [2:0]         sel;
        logic signed [31:0] val;
        logic               rep;
    } command_t;

    logic clk = 1'b0;
    logic rst_n;

    rcbd_rx_if  rx_ch ();
    rcbd_res_if res_ch ();

    remote_command_byte_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // decoder state as the predictor sees it
    gear_t       gear_q;
    bit          frame_open_q;
    int          frame_len_q;
    logic [7:0]  selector_q;
    logic [7:0]  fourth_q;
    int          gain_acc_q;

    command_t    predicted_cmd_q[$];
    int          n_err = 0;
    int          sent_count = 0;
    bit          src_idle_en = 1'b1;
    bit          sink_idle_en = 1'b1;
    int          sink_hold_cycles = 0;

    function automatic void clear_frame();
        frame_open_q = 1'b0;
        frame_len_q  = 0;
        selector_q   = '0;
        fourth_q     = '0;
        gain_acc_q   = 0;
    endfunction

    function automatic command_t predict_command(input logic [7:0] b);
        command_t c;
        longint   v;
        c.motion = MOTION_STOP;
        c.wr     = 1'b0;
        c.sel    = '0;
        c.val    = '0;
        c.rep    = 1'b0;
        if (b == CH_LOW_GEAR)
            gear_q = GEAR_LOW;
        if (b == CH_HIGH_GEAR)
            gear_q = GEAR_HIGH;
        if (b == CH_OPEN)
            frame_open_q = 1'b1;
        if (b == CH_CLOSE)
        begin
            if (fourth_q == CH_REPORT)
                c.rep = 1'b1;
            else if (selector_q >= CH_ZERO && selector_q <= CH_LAST_SEL)
            begin
                c.wr  = 1'b1;
                c.sel = 3'(selector_q - CH_ZERO);
                c.val = gain_acc_q;
            end
            clear_frame();
        end
        else if (frame_open_q && frame_len_q < FRAME_DEPTH)
        begin
            if (frame_len_q == 1)
                selector_q = b;
            if (frame_len_q == 3)
                fourth_q = b;
            if (frame_len_q >= 3)
            begin
                v = longint'(gain_acc_q) * 10 + longint'(b) - 48;
                if (v > 64'sd2147483647)
                    v = 64'sd2147483647;
                if (v < -64'sd2147483648)
                    v = -64'sd2147483648;
                gain_acc_q = int'(v);
            end
            frame_len_q++;
        end
        case (b)
            CH_FORWARD:                       c.motion = MOTION_FORWARD;
            CH_BACK:                          c.motion = MOTION_BACK;
            CH_LEFT_0, CH_LEFT_1, CH_LEFT_2:    c.motion = MOTION_LEFT;
            CH_RIGHT_0, CH_RIGHT_1, CH_RIGHT_2: c.motion = MOTION_RIGHT;
            default:                          c.motion = MOTION_STOP;
        endcase
        c.gear = gear_q;
        return c;
    endfunction

    task automatic note_error(input string msg);
        n_err++;
        if (n_err <= 10)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_result();
        command_t want;
        if (predicted_cmd_q.size() == 0)
        begin
            note_error($sformatf("result with nothing pending, motion=%0d value=%0d",
                                 res_ch.motion, res_ch.param_value));
            return;
        end
        want = predicted_cmd_q.pop_front();
        if (res_ch.motion !== want.motion || res_ch.speed_gear !== want.gear ||
            res_ch.param_write !== want.wr || res_ch.param_select !== want.sel ||
            res_ch.param_value !== want.val || res_ch.report_request !== want.rep)
            note_error($sformatf({"got motion=%0d gear=%0d wr=%0b sel=%0d val=%0d rep=%0b, ",
                                  "want motion=%0d gear=%0d wr=%0b sel=%0d val=%0d rep=%0b"},
                                 res_ch.motion, res_ch.speed_gear, res_ch.param_write,
                                 res_ch.param_select, res_ch.param_value,
                                 res_ch.report_request, want.motion, want.gear, want.wr,
                                 want.sel, want.val, want.rep));
    endtask

    // result side: check accepted items, then drive ready for the next edge
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
                check_result();
            if (sink_hold_cycles > 0)
            begin
                stall_left = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (sink_idle_en)
                res_ch.ready <= ($urandom_range(99) >= 24);
            else
                res_ch.ready <= 1'b1;
        end
    end

    // valid stays high after acceptance; the next call or wait_drained decides
    task automatic send_byte(input logic [7:0] b);
        while (src_idle_en && $urandom_range(99) < 24)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (rx_ch.ready !== 1'b1);
        predicted_cmd_q.push_back(predict_command(b));
        sent_count++;
    endtask

    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        while (predicted_cmd_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] command_byte(input int k);
        case (k)
            0:       return CH_STOP;
            1:       return CH_FORWARD;
            2:       return CH_BACK;
            3:       return CH_RIGHT_0;
            4:       return CH_RIGHT_1;
            5:       return CH_RIGHT_2;
            6:       return CH_LEFT_0;
            7:       return CH_LEFT_1;
            8:       return CH_LEFT_2;
            9:       return CH_HIGH_GEAR;
            10:      return CH_LOW_GEAR;
            11:      return CH_OPEN;
            12:      return CH_CLOSE;
            default: return CH_REPORT;
        endcase
    endfunction

    // body style: 0 digits, 1 bytes below '0' (drives the value negative), 2 anything
    function automatic logic [7:0] body_byte(input int style);
        case (style)
            0:       return CH_ZERO + 8'($urandom_range(9));
            1:       return 8'($urandom_range(47));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_frame();
        int pick;
        int style;
        int body_len;
        pick  = $urandom_range(99);
        style = (pick < 70) ? 0 : (pick < 85) ? 1 : 2;
        send_byte(CH_OPEN);
        pick = $urandom_range(99);
        if (pick < 80)
            send_byte(CH_ZERO + 8'($urandom_range(5)));
        else if (pick < 90)
            send_byte(CH_HASH);
        else
            send_byte(8'($urandom_range(255)));
        send_byte(($urandom_range(99) < 70) ? CH_HASH : body_byte(2));
        if ($urandom_range(99) < 15)
        begin
            send_byte(CH_REPORT);
            body_len = $urandom_range(3);
        end
        else
        begin
            // mostly short values, some that saturate, a few past the frame depth
            pick = $urandom_range(99);
            if (pick < 85)
                body_len = $urandom_range(10);
            else if (pick < 95)
                body_len = $urandom_range(20, 11);
            else
                body_len = $urandom_range(75, 60);
        end
        repeat (body_len)
            send_byte(body_byte(style));
        // an unclosed frame leaves the next open nested inside it
        if ($urandom_range(99) < 95)
            send_byte(CH_CLOSE);
    endtask

    task automatic test_directed_commands();
        send_byte(CH_STOP);
        send_byte(CH_FORWARD);
        send_byte(CH_BACK);
        send_byte(CH_RIGHT_0);
        send_byte(CH_RIGHT_2);
        send_byte(CH_LEFT_0);
        send_byte(CH_LEFT_2);
        send_byte(CH_HIGH_GEAR);
        send_byte(CH_LOW_GEAR);
        send_byte(8'h00);
        send_byte(8'hFF);
        // stray close
        send_byte(CH_CLOSE);
        // report request
        send_byte(CH_OPEN);
        send_byte(CH_LAST_SEL);
        send_byte(CH_HASH);
        send_byte(CH_REPORT);
        send_byte(CH_CLOSE);
        // short frame writes zero
        send_byte(CH_OPEN);
        send_byte(CH_ZERO + 8'd2);
        send_byte(CH_CLOSE);
        // nested open collected as a plain byte
        send_byte(CH_OPEN);
        send_byte(CH_ZERO);
        send_byte(CH_OPEN);
        send_byte(CH_ZERO + 8'd9);
        send_byte(CH_CLOSE);
    endtask

    task automatic test_frames();
        int start;
        start = sent_count;
        while (sent_count - start < 450)
        begin
            if ($urandom_range(99) < 30)
                send_byte(command_byte($urandom_range(13)));
            send_frame();
        end
    endtask

    task automatic test_stream_no_idle();
        int start;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        start = sent_count;
        while (sent_count - start < 120)
        begin
            send_frame();
            send_byte(command_byte($urandom_range(10)));
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        int start;
        sink_hold_cycles = 100;
        start = sent_count;
        while (sent_count - start < 100)
            send_frame();
        wait_drained();
    endtask

    task automatic test_noise();
        repeat (200)
        begin
            if ($urandom_range(99) < 50)
                send_byte(command_byte($urandom_range(13)));
            else
                send_byte(8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        gear_q = GEAR_LOW;
        clear_frame();
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_commands();
        test_frames();
        test_stream_no_idle();
        test_backpressure();
        test_noise();
        wait_drained();
        repeat (8)
            @(posedge clk);
        if (predicted_cmd_q.size() != 0)
            note_error($sformatf("%0d results never arrived", predicted_cmd_q.size()));
        if (n_err == 0)
            $display("[remote_command_byte_decoder] OK");
        else
            $display("[remote_command_byte_decoder] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[remote_command_byte_decoder] ERROR");
        $finish;
    end

endmodule
